FILE: rtl/pgna_pkg.sv
`timescale 1ns / 1ps

package pgna_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int CSR_W    = 7;
   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 2 * SAMPLE_W;
   localparam int RES_W    = SAMPLE_W + 2;
   localparam int NPORTS   = 4;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef logic [ROW_W-1:0]         row_type;
   typedef logic [COL_W-1:0]         col_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [WORD_W-1:0]        word_type;
   typedef logic [CSR_W-1:0]         csr_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [RES_W-1:0]  result_type;

   // Cells are stored row-major with a power-of-two row pitch.
   function automatic addr_type cell_addr(input row_type r, input col_type c);
      return {r, c};
   endfunction

   function automatic result_type ext_re(input word_type w);
      return result_type'($signed(w[SAMPLE_W-1:0]));
   endfunction

   function automatic result_type ext_im(input word_type w);
      return result_type'($signed(w[WORD_W-1:SAMPLE_W]));
   endfunction

   // Saturates a size register to the range 2..max_size.
   function automatic csr_type clamp_size(input csr_type v, input int max_size);
      if (int'(v) < 2) begin
         return csr_type'(2);
      end else if (int'(v) > max_size) begin
         return csr_type'(max_size);
      end else begin
         return v;
      end
   endfunction

endpackage

FILE: rtl/periodic_grid_neighbour_averages.sv
`timescale 1ns / 1ps

// Periodic grid neighbour averages.
// Request channel (req_valid/req_ready): a write item stores one complex sample at
// (row, col); a read item asks for the center value and the row, column and diagonal
// neighbour means of one cell, with indices wrapping at the configured grid size.
// Response channel (rsp_valid/rsp_ready): one item per read, none per write. All
// values are scaled by four. An address beyond the configured size is flagged with
// rsp_out_of_range and zero values on a read, and dropped on a write.
// Configuration (csr_we/csr_index/csr_wdata) sets rows and columns; write it only
// while the block is idle.
// Sequence: a write is stored as it is accepted. A read is accepted, then fetches nine
// cells through two mirrored memories of two read ports each, takes the last read
// data and loads the response register.
// An out-of-range read skips the fetches. Items are processed one at a time.
// A new request is accepted while the previous response still waits; a stalled
// receiver holds the block only when a further response is ready to be loaded.
// Reset clears the control state and sets both sizes to 64; the sample memory is not
// cleared, and every cell must be written before it is read.
module periodic_grid_neighbour_averages (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  pgna_pkg::row_type    req_row,
   input  pgna_pkg::col_type    req_col,
   input  pgna_pkg::sample_type req_sample_re,
   input  pgna_pkg::sample_type req_sample_im,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pgna_pkg::result_type rsp_center_re,
   output pgna_pkg::result_type rsp_center_im,
   output pgna_pkg::result_type rsp_row_avg_re,
   output pgna_pkg::result_type rsp_row_avg_im,
   output pgna_pkg::result_type rsp_col_avg_re,
   output pgna_pkg::result_type rsp_col_avg_im,
   output pgna_pkg::result_type rsp_diag_avg_re,
   output pgna_pkg::result_type rsp_diag_avg_im,
   output logic                 rsp_out_of_range,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  pgna_pkg::csr_type    csr_wdata
);

   import pgna_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [1:0] STEP_LAST = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] step_ff, step_in;

   csr_type rows_ff, cols_ff;
   csr_type nr, nc;

   row_type r_ff, rm_ff, rp_ff;
   col_type c_ff, cm_ff, cp_ff;
   logic    oor_ff;

   row_type rm, rp;
   col_type cm, cp;
   csr_type row_next, col_next;
   logic    req_oor;
   logic    accept;

   logic     mem_we;
   addr_type mem_waddr;
   word_type mem_wdata;

   word_type grid_a_ff [0:DEPTH-1];
   word_type grid_b_ff [0:DEPTH-1];
   addr_type rd_addr [0:NPORTS-1];
   word_type rd_data_ff [0:NPORTS-1];

   word_type x_ff, u0_ff, u1_ff, v0_ff, v1_ff, d0_ff, d1_ff, d2_ff, d3_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, load_out;
   result_type center_re_ff, center_im_ff, row_re_ff, row_im_ff;
   result_type col_re_ff, col_im_ff, diag_re_ff, diag_im_ff;
   logic       oor_out_ff;

   always_comb begin
      nr = clamp_size(rows_ff, MAX_ROWS);
      nc = clamp_size(cols_ff, MAX_COLS);
      req_oor = ({1'b0, req_row} >= nr) || ({1'b0, req_col} >= nc);
      row_next = {1'b0, req_row} + csr_type'(1);
      col_next = {1'b0, req_col} + csr_type'(1);
      if (req_row == '0) begin
         rm = row_type'(nr - csr_type'(1));
      end else begin
         rm = req_row - row_type'(1);
      end
      if (req_col == '0) begin
         cm = col_type'(nc - csr_type'(1));
      end else begin
         cm = req_col - col_type'(1);
      end
      if (row_next == nr) begin
         rp = '0;
      end else begin
         rp = row_type'(row_next);
      end
      if (col_next == nc) begin
         cp = '0;
      end else begin
         cp = col_type'(col_next);
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load_out  = (state_ff == ST_FINISH) && out_free;

   // Writes are taken only in idle, so they never overlap the fetches of a read.
   assign mem_we    = accept && (req_operation == OP_WRITE) && !req_oor;
   assign mem_waddr = cell_addr(req_row, req_col);
   assign mem_wdata = {req_sample_im, req_sample_re};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && (req_operation == OP_READ)) begin
               state_in = req_oor ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            step_in = step_ff + 2'd1;
            if (step_ff == STEP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      case (step_ff)
         2'd0: begin
            rd_addr[0] = cell_addr(r_ff, c_ff);
            rd_addr[1] = cell_addr(rm_ff, c_ff);
            rd_addr[2] = cell_addr(rp_ff, c_ff);
            rd_addr[3] = cell_addr(r_ff, cm_ff);
         end
         2'd1: begin
            rd_addr[0] = cell_addr(r_ff, cp_ff);
            rd_addr[1] = cell_addr(rm_ff, cm_ff);
            rd_addr[2] = cell_addr(rm_ff, cp_ff);
            rd_addr[3] = cell_addr(rp_ff, cm_ff);
         end
         default: begin
            rd_addr[0] = cell_addr(rp_ff, cp_ff);
            rd_addr[1] = cell_addr(rp_ff, cp_ff);
            rd_addr[2] = cell_addr(rp_ff, cp_ff);
            rd_addr[3] = cell_addr(rp_ff, cp_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_a_ff[mem_waddr] <= mem_wdata;
         grid_b_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff[0] <= grid_a_ff[rd_addr[0]];
      rd_data_ff[1] <= grid_a_ff[rd_addr[1]];
      rd_data_ff[2] <= grid_b_ff[rd_addr[2]];
      rd_data_ff[3] <= grid_b_ff[rd_addr[3]];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r_ff   <= req_row;
         c_ff   <= req_col;
         rm_ff  <= rm;
         rp_ff  <= rp;
         cm_ff  <= cm;
         cp_ff  <= cp;
         oor_ff <= req_oor;
      end
      if (state_ff == ST_READ) begin
         case (step_ff)
            2'd1: begin
               x_ff  <= rd_data_ff[0];
               u0_ff <= rd_data_ff[1];
               u1_ff <= rd_data_ff[2];
               v0_ff <= rd_data_ff[3];
            end
            2'd2: begin
               v1_ff <= rd_data_ff[0];
               d0_ff <= rd_data_ff[1];
               d1_ff <= rd_data_ff[2];
               d2_ff <= rd_data_ff[3];
            end
            2'd3: begin
               d3_ff <= rd_data_ff[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         oor_out_ff <= oor_ff;
         if (oor_ff) begin
            center_re_ff <= '0;
            center_im_ff <= '0;
            row_re_ff    <= '0;
            row_im_ff    <= '0;
            col_re_ff    <= '0;
            col_im_ff    <= '0;
            diag_re_ff   <= '0;
            diag_im_ff   <= '0;
         end else begin
            center_re_ff <= ext_re(x_ff) <<< 2;
            center_im_ff <= ext_im(x_ff) <<< 2;
            row_re_ff    <= (ext_re(u0_ff) + ext_re(u1_ff)) <<< 1;
            row_im_ff    <= (ext_im(u0_ff) + ext_im(u1_ff)) <<< 1;
            col_re_ff    <= (ext_re(v0_ff) + ext_re(v1_ff)) <<< 1;
            col_im_ff    <= (ext_im(v0_ff) + ext_im(v1_ff)) <<< 1;
            diag_re_ff   <= ext_re(d0_ff) + ext_re(d1_ff) + ext_re(d2_ff) + ext_re(d3_ff);
            diag_im_ff   <= ext_im(d0_ff) + ext_im(d1_ff) + ext_im(d2_ff) + ext_im(d3_ff);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= csr_type'(MAX_ROWS);
         cols_ff      <= csr_type'(MAX_COLS);
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROWS: rows_ff <= csr_wdata;
               CSR_COLS: cols_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_center_re    = center_re_ff;
   assign rsp_center_im    = center_im_ff;
   assign rsp_row_avg_re   = row_re_ff;
   assign rsp_row_avg_im   = row_im_ff;
   assign rsp_col_avg_re   = col_re_ff;
   assign rsp_col_avg_im   = col_im_ff;
   assign rsp_diag_avg_re  = diag_re_ff;
   assign rsp_diag_avg_im  = diag_im_ff;
   assign rsp_out_of_range = oor_out_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised without a finished read");

   a_no_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !mem_we)
      else $error("memory written while a read is in progress");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && oor_out_ff) |-> (center_re_ff == '0 && row_re_ff == '0 &&
         col_re_ff == '0 && diag_re_ff == '0 && diag_im_ff == '0))
      else $error("out-of-range response carries nonzero values");

   a_read_takes_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && step_ff != STEP_LAST) |=> (state_ff == ST_READ))
      else $error("read sequence cut short");

endmodule

FILE: dv/tb_periodic_grid_neighbour_averages.sv
`timescale 1ns / 1ps

module tb_periodic_grid_neighbour_averages;
   import pgna_pkg::*;

   typedef struct {
      logic       op;
      row_type    row;
      col_type    col;
      sample_type sample_re;
      sample_type sample_im;
      bit         drain;
   } grid_req_type;

   typedef struct {
      result_type center_re;
      result_type center_im;
      result_type row_avg_re;
      result_type row_avg_im;
      result_type col_avg_re;
      result_type col_avg_im;
      result_type diag_avg_re;
      result_type diag_avg_im;
      logic       out_of_range;
   } grid_avgs_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_operation = OP_WRITE;
   row_type    req_row = '0;
   col_type    req_col = '0;
   sample_type req_sample_re = '0;
   sample_type req_sample_im = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   result_type rsp_center_re;
   result_type rsp_center_im;
   result_type rsp_row_avg_re;
   result_type rsp_row_avg_im;
   result_type rsp_col_avg_re;
   result_type rsp_col_avg_im;
   result_type rsp_diag_avg_re;
   result_type rsp_diag_avg_im;
   logic       rsp_out_of_range;
   logic       csr_we = 1'b0;
   logic       csr_index = CSR_ROWS;
   csr_type    csr_wdata = '0;

   periodic_grid_neighbour_averages dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_sample_re    (req_sample_re),
      .req_sample_im    (req_sample_im),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_center_re    (rsp_center_re),
      .rsp_center_im    (rsp_center_im),
      .rsp_row_avg_re   (rsp_row_avg_re),
      .rsp_row_avg_im   (rsp_row_avg_im),
      .rsp_col_avg_re   (rsp_col_avg_re),
      .rsp_col_avg_im   (rsp_col_avg_im),
      .rsp_diag_avg_re  (rsp_diag_avg_re),
      .rsp_diag_avg_im  (rsp_diag_avg_im),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   grid_req_type  pending_requests[$];
   grid_avgs_type expected_averages[$];
   grid_req_type  next_request;
   grid_avgs_type oldest_average;
   logic       req_fire = 1'b0;
   int         mismatches = 0;
   int         sender_idle_pct = 0;
   int         receiver_idle_pct = 0;
   int         holds_requested = 0;
   int         holds_served = 0;
   int         hold_left = 0;

   word_type   grid_mem [MAX_ROWS][MAX_COLS];
   csr_type    rows_reg = csr_type'(64);
   csr_type    cols_reg = csr_type'(64);

   int         gen_rows = MAX_ROWS;
   int         gen_cols = MAX_COLS;
   bit         gen_written [MAX_ROWS][MAX_COLS];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int saturate_size(int v, int limit);
      if (v < 2) begin
         return 2;
      end else if (v > limit) begin
         return limit;
      end
      return v;
   endfunction

   function automatic int wrap_prev(int i, int n);
      return (i == 0) ? n - 1 : i - 1;
   endfunction

   function automatic int wrap_next(int i, int n);
      return (i + 1 == n) ? 0 : i + 1;
   endfunction

   function automatic int re_of(word_type w);
      sample_type s;
      s = w[SAMPLE_W-1:0];
      return int'(s);
   endfunction

   function automatic int im_of(word_type w);
      sample_type s;
      s = w[WORD_W-1:SAMPLE_W];
      return int'(s);
   endfunction

   function automatic void predict_averages(logic op, int r, int c, word_type w);
      grid_avgs_type e;
      int nr, nc, rm, rp, cm, cp;
      nr = saturate_size(int'(rows_reg), MAX_ROWS);
      nc = saturate_size(int'(cols_reg), MAX_COLS);
      e = '{default: '0};
      if (r >= nr || c >= nc) begin
         if (op == OP_READ) begin
            e.out_of_range = 1'b1;
            expected_averages.insert(expected_averages.size(), e);
         end
         return;
      end
      if (op == OP_WRITE) begin
         grid_mem[r][c] = w;
         return;
      end
      rm = wrap_prev(r, nr);
      rp = wrap_next(r, nr);
      cm = wrap_prev(c, nc);
      cp = wrap_next(c, nc);
      e.center_re = result_type'(4 * re_of(grid_mem[r][c]));
      e.center_im = result_type'(4 * im_of(grid_mem[r][c]));
      e.row_avg_re = result_type'(2 * (re_of(grid_mem[rm][c]) + re_of(grid_mem[rp][c])));
      e.row_avg_im = result_type'(2 * (im_of(grid_mem[rm][c]) + im_of(grid_mem[rp][c])));
      e.col_avg_re = result_type'(2 * (re_of(grid_mem[r][cm]) + re_of(grid_mem[r][cp])));
      e.col_avg_im = result_type'(2 * (im_of(grid_mem[r][cm]) + im_of(grid_mem[r][cp])));
      e.diag_avg_re = result_type'(re_of(grid_mem[rm][cm]) + re_of(grid_mem[rm][cp])
                                   + re_of(grid_mem[rp][cm]) + re_of(grid_mem[rp][cp]));
      e.diag_avg_im = result_type'(im_of(grid_mem[rm][cm]) + im_of(grid_mem[rm][cp])
                                   + im_of(grid_mem[rp][cm]) + im_of(grid_mem[rp][cp]));
      expected_averages.insert(expected_averages.size(), e);
   endfunction

   function automatic void check_field(string name, result_type want, result_type got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_requests.size() != 0
             && !(pending_requests[0].drain && expected_averages.size() != 0)
             && $urandom_range(99) >= sender_idle_pct) begin
            next_request = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_request.op;
            req_row <= next_request.row;
            req_col <= next_request.col;
            req_sample_re <= next_request.sample_re;
            req_sample_im <= next_request.sample_im;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != holds_requested) begin
         holds_served <= holds_requested;
         hold_left <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready && !reset;
      if (reset) begin
         rows_reg = csr_type'(64);
         cols_reg = csr_type'(64);
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROWS) begin
               rows_reg = csr_wdata;
            end else begin
               cols_reg = csr_wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               $error("response with no read waiting for it");
               mismatches++;
            end else begin
               oldest_average = expected_averages.pop_front();
               check_field("center_re", oldest_average.center_re, rsp_center_re);
               check_field("center_im", oldest_average.center_im, rsp_center_im);
               check_field("row_avg_re", oldest_average.row_avg_re, rsp_row_avg_re);
               check_field("row_avg_im", oldest_average.row_avg_im, rsp_row_avg_im);
               check_field("col_avg_re", oldest_average.col_avg_re, rsp_col_avg_re);
               check_field("col_avg_im", oldest_average.col_avg_im, rsp_col_avg_im);
               check_field("diag_avg_re", oldest_average.diag_avg_re, rsp_diag_avg_re);
               check_field("diag_avg_im", oldest_average.diag_avg_im, rsp_diag_avg_im);
               check_field("out_of_range", {17'd0, oldest_average.out_of_range},
                           {17'd0, rsp_out_of_range});
            end
         end
         if (req_valid && req_ready) begin
            predict_averages(req_operation, int'(req_row), int'(req_col),
                             {req_sample_im, req_sample_re});
         end
      end
   end

   function automatic int pick_sample();
      case ($urandom_range(9))
         0: return -32768;
         1: return 32767;
         2: return -1;
         3: return 0;
         default: return int'(sample_type'($urandom));
      endcase
   endfunction

   task automatic push_item(logic op, int r, int c, int re, int im, bit drain);
      grid_req_type it;
      it.op = op;
      it.row = row_type'(r);
      it.col = col_type'(c);
      it.sample_re = sample_type'(re);
      it.sample_im = sample_type'(im);
      it.drain = drain;
      pending_requests.insert(pending_requests.size(), it);
      if (op == OP_WRITE && r < gen_rows && c < gen_cols) begin
         gen_written[r][c] = 1'b1;
      end
   endtask

   task automatic fill_neighbourhood(int r, int c, inout int pushed);
      int rs[3];
      int cs[3];
      rs = '{wrap_prev(r, gen_rows), r, wrap_next(r, gen_rows)};
      cs = '{wrap_prev(c, gen_cols), c, wrap_next(c, gen_cols)};
      foreach (rs[i]) begin
         foreach (cs[j]) begin
            if (!gen_written[rs[i]][cs[j]]) begin
               push_item(OP_WRITE, rs[i], cs[j], pick_sample(), pick_sample(), 1'b0);
               pushed++;
            end
         end
      end
   endtask

   task automatic random_items(int n);
      int pushed, roll, r, c;
      bit drain;
      pushed = 0;
      while (pushed < n) begin
         roll = $urandom_range(99);
         r = $urandom_range(gen_rows - 1);
         c = $urandom_range(gen_cols - 1);
         drain = (pushed % 97) == 96;
         if (roll >= 88 && (gen_rows < MAX_ROWS || gen_cols < MAX_COLS)) begin
            if (gen_cols == MAX_COLS || (gen_rows < MAX_ROWS && $urandom_range(1) == 1)) begin
               r = $urandom_range(MAX_ROWS - 1, gen_rows);
               c = $urandom_range(MAX_COLS - 1);
            end else begin
               r = $urandom_range(MAX_ROWS - 1);
               c = $urandom_range(MAX_COLS - 1, gen_cols);
            end
            if (roll < 95) begin
               push_item(OP_READ, r, c, pick_sample(), pick_sample(), drain);
               pushed++;
            end else begin
               push_item(OP_WRITE, r, c, pick_sample(), pick_sample(), 1'b0);
            end
         end else if (roll < 40) begin
            push_item(OP_WRITE, r, c, pick_sample(), pick_sample(), drain);
            pushed++;
         end else begin
            fill_neighbourhood(r, c, pushed);
            push_item(OP_READ, r, c, pick_sample(), pick_sample(), drain);
            pushed++;
         end
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_valid || expected_averages.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(logic idx, csr_type value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_sizes(int rows_value, int cols_value);
      write_size(CSR_ROWS, csr_type'(rows_value));
      write_size(CSR_COLS, csr_type'(cols_value));
      gen_rows = saturate_size(rows_value, MAX_ROWS);
      gen_cols = saturate_size(cols_value, MAX_COLS);
   endtask

   task automatic directed_items();
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 3; c++) begin
            push_item(OP_WRITE, r, c, -32768, 32767, 1'b0);
         end
      end
      push_item(OP_READ, 0, 0, 0, 0, 1'b0);
      for (int r = 0; r < 2; r++) begin
         for (int c = 0; c < 3; c++) begin
            push_item(OP_WRITE, r, c, 32767, -32768, 1'b0);
         end
      end
      push_item(OP_READ, 1, 2, -1, -1, 1'b0);
      push_item(OP_WRITE, 1, 1, -1, 0, 1'b0);
      push_item(OP_WRITE, 0, 2, 1, -1, 1'b0);
      push_item(OP_READ, 0, 1, 23130, -21846, 1'b0);
      push_item(OP_READ, 1, 0, 0, 0, 1'b1);
      push_item(OP_WRITE, 2, 0, 12345, -12345, 1'b0);
      push_item(OP_READ, 2, 0, 0, 0, 1'b0);
      push_item(OP_READ, 63, 63, 0, 0, 1'b0);
      push_item(OP_READ, 0, 3, 0, 0, 1'b0);
   endtask

   task automatic run_phase(int rows_value, int cols_value, int n, int s_pct, int r_pct,
                            bit long_hold);
      wait_idle();
      set_sizes(rows_value, cols_value);
      @(posedge clock);
      sender_idle_pct = s_pct;
      receiver_idle_pct = r_pct;
      if (long_hold) begin
         holds_requested++;
      end
      random_items(n);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_sizes(0, 3);
      @(posedge clock);
      sender_idle_pct = 36;
      receiver_idle_pct = 53;
      directed_items();
      run_phase(64, 127, 150, 36, 53, 1'b0);
      run_phase(5, 7, 150, 36, 53, 1'b0);
      run_phase(127, 2, 150, 53, 36, 1'b0);
      run_phase(1, 0, 100, 53, 36, 1'b0);
      run_phase(3, 64, 150, 0, 0, 1'b1);
      run_phase(17, 9, 180, 0, 0, 1'b0);
      wait_idle();
      if (mismatches == 0) begin
         $display("periodic_grid_neighbour_averages: match");
      end else begin
         $display("periodic_grid_neighbour_averages: mismatch");
      end
      $finish;
   end

   initial begin
      #3600000;
      $display("periodic_grid_neighbour_averages: mismatch");
      $finish;
   end

endmodule
